[design/glyph_text_bounds_measure_macros.svh]
// ---------------------------------------------------------------------------
// glyph text bounds measure assertion macros
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef GLYPH_TEXT_BOUNDS_MEASURE_MACROS_SVH
`define GLYPH_TEXT_BOUNDS_MEASURE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GTB_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define GTB_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define GTB_ASSERT_IMP(label, clk, rst_n, a, c)
`define GTB_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

[design/gtbm_pkg.sv]
// ---------------------------------------------------------------------------
// gtbm_pkg
// shared types and constants of the text bounds engine
// ---------------------------------------------------------------------------
`default_nettype none
package gtbm_pkg;
  localparam int RANGE_SLOTS = 256;
  localparam int GLYPH_SLOTS = 4096;
  localparam int RA_W = $clog2(RANGE_SLOTS);
  localparam int GA_W = $clog2(GLYPH_SLOTS);
  localparam int CP_W = 21;
  localparam logic [CP_W-1:0] FALLBACK_CP = 21'h3f;

  typedef enum logic [1:0] {
    CMD_LOAD_RANGE = 2'd0,
    CMD_LOAD_GLYPH = 2'd1,
    CMD_MEASURE    = 2'd2,
    CMD_FINISH     = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_START_X = 2'd0;
  localparam logic [1:0] REG_START_Y = 2'd1;
  localparam logic [1:0] REG_RANGE_COUNT = 2'd2;

  typedef struct packed {
    logic [20:0] first;
    logic [20:0] last;
    logic [11:0] offset;
  } range_ent_t;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] top;
    logic [7:0] width;
    logic [7:0] height;
    logic [7:0] advance;
  } glyph_ent_t;

  typedef struct packed {
    logic start;
    logic [CP_W-1:0] cp;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic found;
    logic [GA_W-1:0] slot;
  } srch_rsp_t;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    else if (v < -20'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction
endpackage
`default_nettype wire

[design/gtbm_range_search.sv]
// ---------------------------------------------------------------------------
// gtbm_range_search
// range table memory and binary search sequencer, one table read per step
// ---------------------------------------------------------------------------
`default_nettype none
module gtbm_range_search (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    wr_en,
  input  wire logic [gtbm_pkg::RA_W-1:0] wr_addr,
  input  wire gtbm_pkg::range_ent_t    wr_data,
  input  wire logic [8:0]              count,
  input  wire gtbm_pkg::srch_req_t     req,
  output gtbm_pkg::srch_rsp_t          rsp
);
  import gtbm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADDR = 4'b0010,
    S_WAIT = 4'b0100,
    S_CMP  = 4'b1000
  } st_t;

  range_ent_t mem [RANGE_SLOTS];
  range_ent_t rd_r;
  st_t st_r, st_nxt;
  logic [RA_W:0] lo_r, lo_nxt, hi_r, hi_nxt, mid;
  logic [CP_W-1:0] cp_r, cp_nxt;
  logic done_r, done_nxt, found_r, found_nxt;
  logic [GA_W-1:0] slot_r, slot_nxt;
  logic [21:0] sum;
  logic [RA_W:0] cnt;

  assign cnt = (count > 9'(RANGE_SLOTS)) ? (RA_W+1)'(RANGE_SLOTS) : (RA_W+1)'(count);
  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign sum = 22'(rd_r.offset) + 22'(cp_r - rd_r.first);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[mid[RA_W-1:0]];
  end

  always_comb begin
    st_nxt = st_r; lo_nxt = lo_r; hi_nxt = hi_r; cp_nxt = cp_r;
    done_nxt = 1'b0; found_nxt = found_r; slot_nxt = slot_r;
    case (st_r)
      S_IDLE: if (req.start) begin
        cp_nxt = req.cp; lo_nxt = '0; hi_nxt = cnt; st_nxt = S_ADDR;
      end
      S_ADDR: begin
        if (lo_r < hi_r) st_nxt = S_WAIT;
        else begin
          found_nxt = 1'b0; done_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      S_WAIT: st_nxt = S_CMP;
      S_CMP: begin
        st_nxt = S_ADDR;
        if (cp_r < rd_r.first) hi_nxt = mid;
        else if (cp_r > rd_r.last) lo_nxt = mid + 1'b1;
        else begin
          found_nxt = (sum < 22'(GLYPH_SLOTS));
          slot_nxt = sum[GA_W-1:0];
          done_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; done_r <= 1'b0;
    end else begin
      st_r <= st_nxt; done_r <= done_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; cp_r <= cp_nxt;
    found_r <= found_nxt; slot_r <= slot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.found = found_r;
  assign rsp.slot = slot_r;
endmodule
`default_nettype wire

[design/glyph_text_bounds_measure.sv]
// ---------------------------------------------------------------------------
// glyph_text_bounds_measure
// text bounds engine: range search, glyph metrics lookup and box update
// ---------------------------------------------------------------------------
// channel  dir  payload
// in_      in   tdata: cmd, entry_index, range_first/last/offset, glyph metrics,
//               codepoint, is_combining
// out_     out  tdata: box edges, width, height, printable
// cfg_     in   index 2 bits, data 16 bits
// loads stay in M_IDLE; a finish passes M_OUT and waits for its result transfer
// a measure runs the range search, each step via S_ADDR, S_WAIT and S_CMP,
// on a miss a second search for the fallback codepoint, then M_GRD, M_GWAIT
// and M_UPD for glyph read and box update; the range table has a single read port
// reset is synchronous; tables are undefined until written
// in_tready is low while an item is in work or a result waits
// ---------------------------------------------------------------------------
`default_nettype none
`include "glyph_text_bounds_measure_macros.svh"
module glyph_text_bounds_measure (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // cmd, entry_index, range_first, range_last, range_offset, glyph_left,
  // glyph_top, glyph_width, glyph_height, glyph_advance, codepoint,
  // is_combining; zero padded
  input  wire logic [135:0] in_tdata,
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // box_min_x, box_min_y, box_max_x, box_max_y, text_width, text_height,
  // printable; zero padded
  output      logic [103:0] out_tdata,
  input  wire logic         cfg_valid,
  output      logic         cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import gtbm_pkg::*;

  typedef enum logic [6:0] {
    M_IDLE  = 7'b0000001,
    M_SRCH1 = 7'b0000010,
    M_SRCH2 = 7'b0000100,
    M_GRD   = 7'b0001000,
    M_GWAIT = 7'b0010000,
    M_UPD   = 7'b0100000,
    M_OUT   = 7'b1000000
  } mst_t;

  logic [1:0] f_cmd;
  logic [11:0] f_idx, f_off;
  logic [20:0] f_first, f_last, f_cp;
  logic [7:0] f_left, f_top, f_w, f_h, f_adv;
  logic f_comb;
  assign f_cmd = in_tdata[1:0];
  assign f_idx = in_tdata[13:2];
  assign f_first = in_tdata[34:14];
  assign f_last = in_tdata[55:35];
  assign f_off = in_tdata[67:56];
  assign f_left = in_tdata[75:68];
  assign f_top = in_tdata[83:76];
  assign f_w = in_tdata[91:84];
  assign f_h = in_tdata[99:92];
  assign f_adv = in_tdata[107:100];
  assign f_cp = in_tdata[128:108];
  assign f_comb = in_tdata[129];

  mst_t st_r, st_nxt;
  logic signed [15:0] sx_r, sy_r;
  logic [8:0] rcnt_r;
  logic signed [15:0] cur_r, bx_r, mnx_r, mny_r, mxx_r, mxy_r;
  logic [7:0] badv_r;
  logic comb_r;
  logic [GA_W-1:0] slot_r;
  glyph_ent_t gmem [GLYPH_SLOTS];
  glyph_ent_t g_r;
  logic [103:0] odata_r;
  logic ovalid_r;

  srch_req_t req;
  srch_rsp_t rsp;
  logic acc, cfg_acc, rwr;

  assign in_tready = (st_r == M_IDLE) && !ovalid_r;
  assign acc = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc = cfg_valid;
  assign rwr = acc && (cmd_t'(f_cmd) == CMD_LOAD_RANGE) && (f_idx < 12'(RANGE_SLOTS));

  assign req.start = (acc && cmd_t'(f_cmd) == CMD_MEASURE) ||
                     (st_r == M_SRCH1 && rsp.done && !rsp.found);
  assign req.cp = (st_r == M_SRCH1) ? FALLBACK_CP : f_cp;

  gtbm_range_search u_srch (
    .clk(clk), .rst_n(rst_n), .wr_en(rwr), .wr_addr(f_idx[RA_W-1:0]),
    .wr_data({f_first, f_last, f_off}), .count(rcnt_r), .req(req), .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (acc && cmd_t'(f_cmd) == CMD_LOAD_GLYPH && 13'(f_idx) < 13'(GLYPH_SLOTS))
      gmem[f_idx[GA_W-1:0]] <= {f_left, f_top, f_w, f_h, f_adv};
    g_r <= gmem[slot_r];
  end

  // box update datapath
  logic signed [19:0] x_e, cx, nminx, nmaxx, nminy, nmaxy, ncur;
  logic signed [15:0] x_s;
  assign cx = 20'(bx_r) + 20'($signed({1'b0, badv_r[7:1]})) -
              20'($signed({1'b0, g_r.width[7:1]}));
  assign x_s = comb_r ? sat16(cx) : cur_r;
  assign x_e = 20'(x_s) + 20'($signed(g_r.left));
  assign nminx = 20'(sat16(x_e));
  assign nmaxx = 20'(sat16(x_e + 20'($signed({1'b0, g_r.width}))));
  assign nminy = 20'(sat16(20'(sy_r) + 20'($signed(g_r.top)) -
                 20'($signed({1'b0, g_r.height}))));
  assign nmaxy = 20'(sat16(20'(sy_r) + 20'($signed(g_r.top))));
  assign ncur = 20'(cur_r) + 20'($signed({1'b0, g_r.advance}));

  logic [16:0] wd, hd;
  logic [15:0] ww, hh;
  assign wd = 17'(mxx_r) - 17'(mnx_r);
  assign hd = 17'(mxy_r) - 17'(mny_r);
  assign ww = wd[16] ? 16'(0) : wd[15:0];
  assign hh = hd[16] ? 16'(0) : hd[15:0];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      M_IDLE: if (acc) begin
        if (cmd_t'(f_cmd) == CMD_MEASURE) st_nxt = M_SRCH1;
        else if (cmd_t'(f_cmd) == CMD_FINISH) st_nxt = M_OUT;
      end
      M_SRCH1: if (rsp.done) st_nxt = rsp.found ? M_GRD : M_SRCH2;
      M_SRCH2: if (rsp.done) st_nxt = rsp.found ? M_GRD : M_IDLE;
      M_GRD: st_nxt = M_GWAIT;
      M_GWAIT: st_nxt = M_UPD;
      M_UPD: st_nxt = M_IDLE;
      M_OUT: st_nxt = M_IDLE;
      default: st_nxt = M_IDLE;
    endcase
  end

  logic clr;
  assign clr = (st_r == M_OUT) ||
               (cfg_acc && (cfg_index == REG_START_X || cfg_index == REG_START_Y));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= M_IDLE; ovalid_r <= 1'b0;
      sx_r <= '0; sy_r <= '0; rcnt_r <= '0;
      cur_r <= '0; bx_r <= '0; badv_r <= '0;
      mnx_r <= '0; mxx_r <= '0; mny_r <= '0; mxy_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      if (st_r == M_OUT) begin
        ovalid_r <= 1'b1;
        odata_r <= {7'd0, (ww != 16'd0 || hh != 16'd0), hh, ww,
                    mxy_r, mxx_r, mny_r, mnx_r};
      end
      if (cfg_acc && cfg_index == REG_START_X) sx_r <= cfg_data;
      if (cfg_acc && cfg_index == REG_START_Y) sy_r <= cfg_data;
      if (cfg_acc && cfg_index == REG_RANGE_COUNT) rcnt_r <= cfg_data[8:0];
      if (clr) begin
        cur_r <= (cfg_acc && cfg_index == REG_START_X) ? cfg_data : sx_r;
        bx_r <= (cfg_acc && cfg_index == REG_START_X) ? cfg_data : sx_r;
        mnx_r <= (cfg_acc && cfg_index == REG_START_X) ? cfg_data : sx_r;
        mxx_r <= (cfg_acc && cfg_index == REG_START_X) ? cfg_data : sx_r;
        mny_r <= (cfg_acc && cfg_index == REG_START_Y) ? cfg_data : sy_r;
        mxy_r <= (cfg_acc && cfg_index == REG_START_Y) ? cfg_data : sy_r;
        badv_r <= '0;
      end else if (st_r == M_UPD) begin
        if (nminx < 20'(mnx_r)) mnx_r <= nminx[15:0];
        if (nmaxx > 20'(mxx_r)) mxx_r <= nmaxx[15:0];
        if (nminy < 20'(mny_r)) mny_r <= nminy[15:0];
        if (nmaxy > 20'(mxy_r)) mxy_r <= nmaxy[15:0];
        if (!comb_r) begin
          bx_r <= cur_r; badv_r <= g_r.advance; cur_r <= sat16(ncur);
        end
      end
    end
    if (acc) begin
      comb_r <= f_comb;
    end
    if ((st_r == M_SRCH1 || st_r == M_SRCH2) && rsp.done) slot_r <= rsp.slot;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;

  `GTB_ASSERT_IMP(a_busy_not_ready, clk, rst_n, st_r != M_IDLE, !in_tready)
  `GTB_ASSERT_NXT(a_finish_out, clk, rst_n, st_r == M_OUT, out_tvalid)
  `GTB_ASSERT_IMP(a_out_blocks, clk, rst_n, out_tvalid, !in_tready)
endmodule
`default_nettype wire
